[sv/rho_pkg.sv]
`timescale 1ns / 1ps

package rho_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam logic signed [30:0] LAT_LIMIT_E7 = 31'sd900000000;
    localparam logic [31:0] HALF_TURN_E7 = 32'd1800000000;
    localparam logic [31:0] FULL_TURN_E7 = 32'd3600000000;
    localparam logic signed [33:0] HALF_TURN_S = 34'sd1800000000;
    localparam logic signed [33:0] FULL_TURN_S = 34'sd3600000000;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [63:0] PI_WIDE = {PI_Q30, 32'd0};
    localparam logic [31:0] RECIP_K = 32'(PI_WIDE / {32'd0, FULL_TURN_E7});
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;
    localparam logic [31:0] EARTH_RADIUS_M = 32'd6371000;
    localparam logic [63:0] SQRT_TOP_BIT = 64'h4000000000000000;
    localparam logic [4:0] LONG_LOOP_LAST = 5'd31;
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_WRAP,
        CS_CMUL,
        CS_CREC,
        CS_CFIX,
        CS_ROT,
        CS_MUL1,
        CS_MUL2,
        CS_MUL3,
        CS_MUL4,
        CS_SUMA,
        CS_SQ1,
        CS_SQ2,
        CS_VEC,
        CS_SEG,
        CS_DONE
    } rho_core_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_FIN
    } rho_top_state_t;

    typedef struct packed {
        logic        done;
        logic [39:0] seg;
    } rho_core_stat_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'd843314857;
                5'd1:  v = 32'd497837829;
                5'd2:  v = 32'd263043837;
                5'd3:  v = 32'd133525159;
                5'd4:  v = 32'd67021687;
                5'd5:  v = 32'd33543516;
                5'd6:  v = 32'd16775851;
                5'd7:  v = 32'd8388437;
                5'd8:  v = 32'd4194283;
                5'd9:  v = 32'd2097149;
                5'd10: v = 32'd1048576;
                5'd11: v = 32'd524288;
                5'd12: v = 32'd262144;
                5'd13: v = 32'd131072;
                5'd14: v = 32'd65536;
                5'd15: v = 32'd32768;
                5'd16: v = 32'd16384;
                5'd17: v = 32'd8192;
                5'd18: v = 32'd4096;
                5'd19: v = 32'd2048;
                5'd20: v = 32'd1024;
                5'd21: v = 32'd512;
                5'd22: v = 32'd256;
                5'd23: v = 32'd128;
                5'd24: v = 32'd64;
                5'd25: v = 32'd32;
                5'd26: v = 32'd16;
                5'd27: v = 32'd8;
                5'd28: v = 32'd4;
                5'd29: v = 32'd2;
                5'd30: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

[sv/route_haversine_odometer.sv]
`timescale 1ns / 1ps

// Route odometer: each accepted word is one route point in degrees times 1e7, and the word
// flagged as the last point produces one output word with the point count and the route
// length in whole metres, after which the block starts a new route. The first point of a
// route skips the segment unit; every later point runs through one shared segment unit
// that, one step per cycle, takes an extra wrap step when the longitude difference needs
// one, runs four angle conversions of three shared multiplies each followed by a 24-step
// CORDIC rotation, four products, two 32-step square roots and one 24-step CORDIC
// vectoring pass that is skipped when the two points give a zero haversine term. A new
// point is taken while an earlier output word still waits; a last point whose output word
// would replace a waiting one holds the input until that word is taken.

module route_haversine_odometer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [30:0] latitude_e7,
    input  logic signed [31:0] longitude_e7,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        points_seen,
    output logic [31:0]        distance_m
);

    rho_pkg::rho_top_state_t state_reg;
    rho_pkg::rho_top_state_t state_next;

    logic signed [30:0] prev_lat_reg;
    logic signed [31:0] prev_lon_reg;
    logic [31:0]        count_reg;
    logic [39:0]        acc_reg;
    logic signed [30:0] cur_lat_reg;
    logic signed [31:0] cur_lon_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic [31:0]        points_reg;
    logic [31:0]        dist_reg;

    logic signed [30:0]      lat_sat;
    logic                    accept;
    logic                    core_start;
    logic                    out_free;
    logic                    fin_go;
    logic [31:0]             count_inc;
    logic [40:0]             acc_sum;
    rho_pkg::rho_core_stat_t core_stat;

    always_comb
    begin
        if (latitude_e7 > rho_pkg::LAT_LIMIT_E7)
        begin
            lat_sat = rho_pkg::LAT_LIMIT_E7;
        end
        else if (latitude_e7 < -rho_pkg::LAT_LIMIT_E7)
        begin
            lat_sat = -rho_pkg::LAT_LIMIT_E7;
        end
        else
        begin
            lat_sat = latitude_e7;
        end
        count_inc = (count_reg == rho_pkg::COUNT_MAX) ? count_reg : count_reg + 32'd1;
        acc_sum   = {1'b0, acc_reg} + {1'b0, core_stat.seg};
        out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rho_pkg::TS_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_reg != 32'd0) ? rho_pkg::TS_RUN : rho_pkg::TS_FIN;
                end
            end
            rho_pkg::TS_RUN: if (core_stat.done) state_next = rho_pkg::TS_FIN;
            rho_pkg::TS_FIN: if (fin_go) state_next = rho_pkg::TS_IDLE;
            default:         state_next = rho_pkg::TS_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != rho_pkg::TS_IDLE);
        accept     = in_valid && (state_reg == rho_pkg::TS_IDLE);
        core_start = accept && (count_reg != 32'd0);
        fin_go     = (state_reg == rho_pkg::TS_FIN) && (!last_reg || out_free);
    end

    rho_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .lat1  (prev_lat_reg),
        .lon1  (prev_lon_reg),
        .lat2  (lat_sat),
        .lon2  (longitude_e7),
        .stat  (core_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rho_pkg::TS_IDLE;
            prev_lat_reg  <= 31'sd0;
            prev_lon_reg  <= 32'sd0;
            count_reg     <= 32'd0;
            acc_reg       <= 40'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rho_pkg::TS_RUN && core_stat.done)
            begin
                acc_reg <= acc_sum[40] ? 40'hFFFFFFFFFF : acc_sum[39:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fin_go)
            begin
                if (last_reg)
                begin
                    prev_lat_reg  <= 31'sd0;
                    prev_lon_reg  <= 32'sd0;
                    count_reg     <= 32'd0;
                    acc_reg       <= 40'd0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    prev_lat_reg <= cur_lat_reg;
                    prev_lon_reg <= cur_lon_reg;
                    count_reg    <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_lat_reg <= lat_sat;
            cur_lon_reg <= longitude_e7;
            last_reg    <= last_point;
        end
        if (fin_go && last_reg)
        begin
            points_reg <= count_inc;
            dist_reg   <= acc_reg[39:8];
        end
    end

    assign out_valid   = out_valid_reg;
    assign points_seen = points_reg;
    assign distance_m  = dist_reg;

endmodule

[sv/rho_core.sv]
`timescale 1ns / 1ps

module rho_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [30:0]      lat1,
    input  logic signed [31:0]      lon1,
    input  logic signed [30:0]      lat2,
    input  logic signed [31:0]      lon2,
    output rho_pkg::rho_core_stat_t stat
);

    rho_pkg::rho_core_state_t state_reg;
    rho_pkg::rho_core_state_t state_next;
    logic [4:0] cnt_reg;
    logic [1:0] k_reg;

    logic signed [30:0] lat1_reg;
    logic signed [30:0] lat2_reg;
    logic signed [31:0] dlat_reg;
    logic signed [33:0] dlon_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        q_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic [31:0]        s1_reg;
    logic [31:0]        s2_reg;
    logic [31:0]        c1_reg;
    logic [31:0]        c2_reg;
    logic [31:0]        t1_reg;
    logic [31:0]        t2_reg;
    logic [31:0]        t3_reg;
    logic [31:0]        t4_reg;
    logic [30:0]        a_reg;
    logic [63:0]        sq_v_reg;
    logic [63:0]        sq_r_reg;
    logic [63:0]        sq_b_reg;
    logic [63:0]        sqy_reg;
    logic [39:0]        seg_reg;

    logic signed [33:0] conv_v;
    logic signed [33:0] conv_mag_full;
    logic               conv_neg;
    logic [31:0]        div_d;
    logic [31:0]        q_est;
    logic [63:0]        fix_r;
    logic               fix_ge;
    logic [31:0]        q_fix;
    logic signed [33:0] theta;

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic               plus;
    logic signed [33:0] cx_step;
    logic signed [33:0] cy_step;
    logic signed [33:0] cz_step;
    logic signed [33:0] mag_y;

    logic [63:0] sq_rb;
    logic        sq_ge;
    logic [63:0] sq_v_new;
    logic [63:0] sq_r_new;

    logic [32:0] a_sum;
    logic [30:0] a_cl;
    logic [30:0] zc;
    logic        in_range;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    always_comb
    begin
        unique case (k_reg)
            2'd0: conv_v = {{2{dlat_reg[31]}}, dlat_reg};
            2'd1: conv_v = dlon_reg;
            2'd2: conv_v = {{3{lat1_reg[30]}}, lat1_reg};
            default: conv_v = {{3{lat2_reg[30]}}, lat2_reg};
        endcase
        conv_neg      = conv_v[33];
        conv_mag_full = conv_neg ? -conv_v : conv_v;
        div_d         = k_reg[1] ? rho_pkg::HALF_TURN_E7 : rho_pkg::FULL_TURN_E7;
    end

    // The reciprocal estimate is at most one below the true quotient, so one
    // compare against the divisor finishes the conversion.
    always_comb
    begin
        q_est  = k_reg[1] ? mul_p[62:31] : mul_p[63:32];
        fix_r  = prod_reg - mul_p;
        fix_ge = fix_r >= {32'd0, div_d};
        q_fix  = q_reg + {31'd0, fix_ge};
        theta  = {2'b00, q_fix};
    end

    always_comb
    begin
        dx      = cy_reg >>> cnt_reg;
        dy      = cx_reg >>> cnt_reg;
        at      = {2'b00, rho_pkg::atan_q30(cnt_reg)};
        plus    = (state_reg == rho_pkg::CS_ROT) ? !cz_reg[33]
                                                 : (cy_reg[33] || cy_reg == 34'sd0);
        cx_step = plus ? cx_reg - dx : cx_reg + dx;
        cy_step = plus ? cy_reg + dy : cy_reg - dy;
        cz_step = plus ? cz_reg - at : cz_reg + at;
        mag_y   = cy_step[33] ? -cy_step : cy_step;
    end

    always_comb
    begin
        sq_rb    = sq_r_reg + sq_b_reg;
        sq_ge    = sq_v_reg >= sq_rb;
        sq_v_new = sq_ge ? sq_v_reg - sq_rb : sq_v_reg;
        sq_r_new = sq_ge ? (sq_r_reg >> 1) + sq_b_reg : sq_r_reg >> 1;
    end

    always_comb
    begin
        a_sum    = {1'b0, t1_reg} + {1'b0, t4_reg};
        a_cl     = (a_sum > {2'b00, rho_pkg::ONE_Q30}) ? rho_pkg::ONE_Q30 : a_sum[30:0];
        zc       = cz_reg[33] ? 31'd0 : cz_reg[30:0];
        in_range = !(dlon_reg >= rho_pkg::HALF_TURN_S) && !(dlon_reg < -rho_pkg::HALF_TURN_S);
        mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rho_pkg::CS_IDLE: if (start) state_next = rho_pkg::CS_WRAP;
            rho_pkg::CS_WRAP: if (in_range) state_next = rho_pkg::CS_CMUL;
            rho_pkg::CS_CMUL: state_next = rho_pkg::CS_CREC;
            rho_pkg::CS_CREC: state_next = rho_pkg::CS_CFIX;
            rho_pkg::CS_CFIX: state_next = rho_pkg::CS_ROT;
            rho_pkg::CS_ROT:
            begin
                if (cnt_reg == rho_pkg::CORDIC_LAST)
                begin
                    state_next = (k_reg == 2'd3) ? rho_pkg::CS_MUL1 : rho_pkg::CS_CMUL;
                end
            end
            rho_pkg::CS_MUL1: state_next = rho_pkg::CS_MUL2;
            rho_pkg::CS_MUL2: state_next = rho_pkg::CS_MUL3;
            rho_pkg::CS_MUL3: state_next = rho_pkg::CS_MUL4;
            rho_pkg::CS_MUL4: state_next = rho_pkg::CS_SUMA;
            rho_pkg::CS_SUMA: state_next = rho_pkg::CS_SQ1;
            rho_pkg::CS_SQ1:
            begin
                if (cnt_reg == rho_pkg::LONG_LOOP_LAST) state_next = rho_pkg::CS_SQ2;
            end
            rho_pkg::CS_SQ2:
            begin
                if (cnt_reg == rho_pkg::LONG_LOOP_LAST)
                begin
                    state_next = (sqy_reg == 64'd0) ? rho_pkg::CS_SEG : rho_pkg::CS_VEC;
                end
            end
            rho_pkg::CS_VEC:
            begin
                if (cnt_reg == rho_pkg::CORDIC_LAST) state_next = rho_pkg::CS_SEG;
            end
            rho_pkg::CS_SEG:  state_next = rho_pkg::CS_DONE;
            rho_pkg::CS_DONE: state_next = rho_pkg::CS_IDLE;
            default:          state_next = rho_pkg::CS_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a     = 32'd0;
        mul_b     = 32'd0;
        stat.done = 1'b0;
        stat.seg  = seg_reg;
        unique case (state_reg)
            rho_pkg::CS_CMUL:
            begin
                mul_a = conv_mag_full[31:0];
                mul_b = rho_pkg::PI_Q30;
            end
            rho_pkg::CS_CREC:
            begin
                mul_a = conv_mag_full[31:0];
                mul_b = rho_pkg::RECIP_K;
            end
            rho_pkg::CS_CFIX:
            begin
                mul_a = q_reg;
                mul_b = div_d;
            end
            rho_pkg::CS_MUL1:
            begin
                mul_a = s1_reg;
                mul_b = s1_reg;
            end
            rho_pkg::CS_MUL2:
            begin
                mul_a = c1_reg;
                mul_b = c2_reg;
            end
            rho_pkg::CS_MUL3:
            begin
                mul_a = s2_reg;
                mul_b = s2_reg;
            end
            rho_pkg::CS_MUL4:
            begin
                mul_a = t2_reg;
                mul_b = t3_reg;
            end
            rho_pkg::CS_SEG:
            begin
                mul_a = {zc, 1'b0};
                mul_b = rho_pkg::EARTH_RADIUS_M;
            end
            rho_pkg::CS_DONE: stat.done = 1'b1;
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rho_pkg::CS_IDLE;
            cnt_reg   <= 5'd0;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
            if (state_reg == rho_pkg::CS_IDLE)
            begin
                k_reg <= 2'd0;
            end
            else if (state_reg == rho_pkg::CS_ROT && cnt_reg == rho_pkg::CORDIC_LAST)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rho_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    lat1_reg <= lat1;
                    lat2_reg <= lat2;
                    dlat_reg <= {lat2[30], lat2} - {lat1[30], lat1};
                    dlon_reg <= {{2{lon2[31]}}, lon2} - {{2{lon1[31]}}, lon1};
                end
            end
            rho_pkg::CS_WRAP:
            begin
                if (dlon_reg >= rho_pkg::HALF_TURN_S)
                begin
                    dlon_reg <= dlon_reg - rho_pkg::FULL_TURN_S;
                end
                else if (dlon_reg < -rho_pkg::HALF_TURN_S)
                begin
                    dlon_reg <= dlon_reg + rho_pkg::FULL_TURN_S;
                end
            end
            rho_pkg::CS_CMUL:
            begin
                prod_reg <= mul_p;
                neg_reg  <= conv_neg;
            end
            rho_pkg::CS_CREC: q_reg <= q_est;
            rho_pkg::CS_CFIX:
            begin
                cx_reg <= rho_pkg::GAIN_Q30;
                cy_reg <= 34'sd0;
                cz_reg <= neg_reg ? -theta : theta;
            end
            rho_pkg::CS_ROT:
            begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
                if (cnt_reg == rho_pkg::CORDIC_LAST)
                begin
                    case (k_reg)
                        2'd0: s1_reg <= mag_y[31:0];
                        2'd1: s2_reg <= mag_y[31:0];
                        2'd2: c1_reg <= cx_step[33] ? 32'd0 : cx_step[31:0];
                        default: c2_reg <= cx_step[33] ? 32'd0 : cx_step[31:0];
                    endcase
                end
            end
            rho_pkg::CS_MUL1: t1_reg <= mul_p[61:30];
            rho_pkg::CS_MUL2: t2_reg <= mul_p[61:30];
            rho_pkg::CS_MUL3: t3_reg <= mul_p[61:30];
            rho_pkg::CS_MUL4: t4_reg <= mul_p[61:30];
            rho_pkg::CS_SUMA:
            begin
                a_reg    <= a_cl;
                sq_v_reg <= {3'b000, a_cl, 30'd0};
                sq_r_reg <= 64'd0;
                sq_b_reg <= rho_pkg::SQRT_TOP_BIT;
            end
            rho_pkg::CS_SQ1:
            begin
                sq_v_reg <= sq_v_new;
                sq_r_reg <= sq_r_new;
                sq_b_reg <= sq_b_reg >> 2;
                if (cnt_reg == rho_pkg::LONG_LOOP_LAST)
                begin
                    sqy_reg  <= sq_r_new;
                    sq_v_reg <= {3'b000, rho_pkg::ONE_Q30 - a_reg, 30'd0};
                    sq_r_reg <= 64'd0;
                    sq_b_reg <= rho_pkg::SQRT_TOP_BIT;
                end
            end
            rho_pkg::CS_SQ2:
            begin
                sq_v_reg <= sq_v_new;
                sq_r_reg <= sq_r_new;
                sq_b_reg <= sq_b_reg >> 2;
                if (cnt_reg == rho_pkg::LONG_LOOP_LAST)
                begin
                    cx_reg <= sq_r_new[33:0];
                    cy_reg <= sqy_reg[33:0];
                    cz_reg <= 34'sd0;
                end
            end
            rho_pkg::CS_VEC:
            begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
            end
            rho_pkg::CS_SEG: seg_reg <= mul_p[61:22];
            default:
            begin
                seg_reg <= seg_reg;
            end
        endcase
    end

endmodule
